[rtl/core/event_slot_dispatcher_assert.svh]
// Assertion helpers used by the checker file.
`ifndef EVENT_SLOT_DISPATCHER_ASSERT_SVH
`define EVENT_SLOT_DISPATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/esd_pkg.sv]
`default_nettype none

package esd_pkg;

  // Default sizing of the slot table
  localparam int SLOTS_DEF        = 32;
  localparam int SOURCES_DEF      = 64;
  localparam int HANDLER_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF   = 16;

  // Fixed widths of the beat fields
  localparam int SRC_W      = 6;
  localparam int HND_IN_W   = 8;
  localparam int LIMIT_IN_W = 16;
  localparam int COND_W     = 64;
  localparam int SLOT_W     = 5;
  localparam int HND_OUT_W  = 8;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] kind_t;

  // Commands
  localparam cmd_t CMD_ASSIGN_REP  = 2'd0;
  localparam cmd_t CMD_ASSIGN_ONCE = 2'd1;
  localparam cmd_t CMD_CLEAR       = 2'd2;
  localparam cmd_t CMD_TICK        = 2'd3;

  // Result kinds
  localparam kind_t KIND_ASSIGN = 2'd0;
  localparam kind_t KIND_ACK    = 2'd1;
  localparam kind_t KIND_FIRE   = 2'd2;
  localparam kind_t KIND_DONE   = 2'd3;

endpackage

`default_nettype wire

[rtl/core/esd_ram.sv]
`default_nettype none

module esd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/event_slot_dispatcher.sv]
// Sequence: an assign walks the active bits to the lowest free slot, a count reset walks
//   every slot, and a tick reads each slot from the memories and then evaluates it; every
//   command ends with a closing beat, and result beats wait on out_tready.
// Throughput: one command at a time; the next one is taken after the closing beat loads.
// Reset: rst_n (synchronous, active low) marks every slot inactive at once;
//   the slot memories need no clearing pass.
`default_nettype none

module event_slot_dispatcher #(
  parameter int SLOTS        = esd_pkg::SLOTS_DEF,
  parameter int SOURCES      = esd_pkg::SOURCES_DEF,
  parameter int HANDLER_BITS = esd_pkg::HANDLER_BITS_DEF,
  parameter int COUNT_BITS   = esd_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  // [5:0] source, [6] has_source, [14:7] handler, [15] has_handler,
  // [31:16] fire_limit, [95:32] conditions
  input  wire logic [95:0]   in_tdata,
  // [1:0] cmd
  input  wire esd_pkg::cmd_t in_tuser,
  output      logic          out_tvalid,
  input  wire logic          out_tready,
  // [4:0] slot, [12:5] fired_handler, [13] call_handler, [14] table_full,
  // [15] zero
  output      logic [15:0]   out_tdata,
  // [1:0] kind
  output      esd_pkg::kind_t out_tuser,
  output      logic          out_tlast
);

  import esd_pkg::*;

  // Slot index and scan counter widths; the counter reaches SLOTS to end a scan.
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  // Slot entry: {one_shot, limit, source, has_source, handler, has_handler}
  localparam int CFG_W = 1 + COUNT_BITS + SRC_W + 1 + HANDLER_BITS + 1;

  localparam logic [CNT_W-1:0]  LAST_IDX  = CNT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [SRC_W:0]    SRC_LIM   = (SRC_W + 1)'(SOURCES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ASSIGN = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_TICK   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic                    ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]        ev_idx_r, ev_idx_nxt;
  logic [SLOTS-1:0]        active_r, active_nxt;

  // Command captured at accept
  logic                    once_r;
  logic [SRC_W-1:0]        src_r;
  logic                    has_src_r;
  logic [HANDLER_BITS-1:0] hnd_r;
  logic                    has_hnd_r;
  logic [COUNT_BITS-1:0]   limit_r;
  logic [COND_W-1:0]       cond_r;

  // Closing beat of the current command
  kind_t                   fin_kind_r, fin_kind_nxt;
  logic [SLOT_W-1:0]       fin_slot_r, fin_slot_nxt;
  logic                    fin_full_r, fin_full_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  kind_t                   out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic [HND_OUT_W-1:0]    out_hnd_r, out_hnd_nxt;
  logic                    out_call_r, out_call_nxt;
  logic                    out_full_r, out_full_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_load;
  logic                    out_busy;

  // Slot memory ports
  logic                    cfg_we;
  logic [IDX_W-1:0]        cfg_waddr;
  logic [CFG_W-1:0]        cfg_wdata;
  logic [CFG_W-1:0]        cfg_rdata;
  logic                    cnt_we;
  logic [IDX_W-1:0]        cnt_waddr;
  logic [COUNT_BITS-1:0]   cnt_wdata;
  logic [COUNT_BITS-1:0]   cnt_rdata;
  logic                    rd_en;

  // Slot under evaluation
  logic                    ev_once;
  logic [COUNT_BITS-1:0]   ev_limit;
  logic [SRC_W-1:0]        ev_src;
  logic                    ev_has_src;
  logic [HANDLER_BITS-1:0] ev_hnd;
  logic                    ev_has_hnd;
  logic                    line_on;
  logic                    under_limit;
  logic                    fire;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic                    stall;
  logic                    in_acc;
  logic [IDX_W-1:0]        scan_idx;

  assign in_acc   = in_tvalid && in_tready;
  assign out_busy = out_valid_r && !out_tready;
  assign scan_idx = idx_r[IDX_W-1:0];

  // Slot entries, written on assign and read one slot per cycle during a tick while no stall holds the scan
  assign cfg_wdata = {once_r, limit_r, src_r, has_src_r, hnd_r, has_hnd_r};
  assign cfg_waddr = scan_idx;

  esd_ram #(
    .WIDTH (CFG_W),
    .DEPTH (SLOTS)
  ) u_cfg_ram (
    .clk     (clk),
    .wr_en   (cfg_we),
    .wr_addr (cfg_waddr),
    .wr_data (cfg_wdata),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (cfg_rdata)
  );

  // Fire counts, read-modify-written by the tick, zeroed by assign and count reset
  esd_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SLOTS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (cnt_rdata)
  );

  assign {ev_once, ev_limit, ev_src, ev_has_src, ev_hnd, ev_has_hnd} = cfg_rdata;

  // Fire decision for the slot whose entry came back from the memories
  assign line_on     = ({1'b0, ev_src} < SRC_LIM) && cond_r[ev_src];
  assign under_limit = !ev_once || (cnt_rdata < ev_limit);
  assign fire        = ev_vld_r && active_r[ev_idx_r] && ev_has_src && line_on && under_limit;
  // Saturate at the top; only one-shot counts are ever compared
  assign cnt_inc     = (cnt_rdata != CNT_MAX) ? cnt_rdata + COUNT_BITS'(1) : cnt_rdata;
  // A firing slot waits in the eval stage while the output register holds a beat that is not taken
  assign stall       = fire && out_busy;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ev_vld_nxt    = ev_vld_r;
    ev_idx_nxt    = ev_idx_r;
    active_nxt    = active_r;
    fin_kind_nxt  = fin_kind_r;
    fin_slot_nxt  = fin_slot_r;
    fin_full_nxt  = fin_full_r;
    out_load      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_hnd_nxt   = out_hnd_r;
    out_call_nxt  = out_call_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    cfg_we        = 1'b0;
    cnt_we        = 1'b0;
    cnt_waddr     = scan_idx;
    cnt_wdata     = '0;
    rd_en         = 1'b0;
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          idx_nxt      = '0;
          ev_vld_nxt   = 1'b0;
          fin_slot_nxt = '0;
          fin_full_nxt = 1'b0;
          case (in_tuser)
            CMD_ASSIGN_REP, CMD_ASSIGN_ONCE: begin
              state_nxt    = ST_ASSIGN;
              fin_kind_nxt = KIND_ASSIGN;
            end
            CMD_CLEAR: begin
              state_nxt    = ST_CLEAR;
              fin_kind_nxt = KIND_ACK;
            end
            default: begin
              state_nxt    = ST_TICK;
              fin_kind_nxt = KIND_DONE;
            end
          endcase
        end
      end

      ST_ASSIGN: begin
        // Walk the active bits for the lowest free slot
        if (!active_r[scan_idx]) begin
          cfg_we               = 1'b1;
          cnt_we               = 1'b1;
          active_nxt[scan_idx] = 1'b1;
          fin_slot_nxt         = SLOT_W'(scan_idx);
          state_nxt            = ST_DONE;
        end else if (idx_r == LAST_IDX) begin
          fin_full_nxt = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      ST_CLEAR: begin
        // Zero every count; repeating counts never reach a result
        cnt_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      ST_TICK: begin
        if (!stall) begin
          if (fire) begin
            cnt_we       = 1'b1;
            cnt_waddr    = ev_idx_r;
            cnt_wdata    = cnt_inc;
            if (ev_once && (cnt_inc >= ev_limit)) begin
              active_nxt[ev_idx_r] = 1'b0;
            end
            out_load     = 1'b1;
            out_kind_nxt = KIND_FIRE;
            out_slot_nxt = SLOT_W'(ev_idx_r);
            out_hnd_nxt  = ev_has_hnd ? HND_OUT_W'(ev_hnd) : '0;
            out_call_nxt = ev_has_hnd;
            out_full_nxt = 1'b0;
            out_last_nxt = 1'b0;
          end
          // Advance the read side one slot
          if (idx_r < SLOTS_CNT) begin
            rd_en      = 1'b1;
            ev_vld_nxt = 1'b1;
            ev_idx_nxt = scan_idx;
            idx_nxt    = idx_r + CNT_W'(1);
          end else begin
            ev_vld_nxt = 1'b0;
            if (!ev_vld_r) begin
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        // Send the closing beat once the output register frees up
        if (!out_busy) begin
          out_load     = 1'b1;
          out_kind_nxt = fin_kind_r;
          out_slot_nxt = fin_slot_r;
          out_hnd_nxt  = '0;
          out_call_nxt = 1'b0;
          out_full_nxt = fin_full_r;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      ev_vld_r    <= 1'b0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ev_vld_r    <= ev_vld_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    ev_idx_r   <= ev_idx_nxt;
    fin_kind_r <= fin_kind_nxt;
    fin_slot_r <= fin_slot_nxt;
    fin_full_r <= fin_full_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_hnd_r  <= out_hnd_nxt;
    out_call_r <= out_call_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc) begin
      once_r    <= (in_tuser == CMD_ASSIGN_ONCE);
      src_r     <= in_tdata[5:0];
      has_src_r <= in_tdata[6];
      hnd_r     <= HANDLER_BITS'(in_tdata[14:7]);
      has_hnd_r <= in_tdata[15];
      limit_r   <= COUNT_BITS'(in_tdata[31:16]);
      cond_r    <= in_tdata[95:32];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_full_r, out_call_r, out_hnd_r, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/core/esd_checker.sv]
`default_nettype none

`include "event_slot_dispatcher_assert.svh"

module esd_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_tvalid,
  input wire logic           in_tready,
  input wire logic           out_tvalid,
  input wire logic           out_tready,
  input wire logic [15:0]    out_tdata,
  input wire esd_pkg::kind_t out_tuser,
  input wire logic           out_tlast
);

  import esd_pkg::*;

  // A stalled result beat holds
  `ESD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result beat changed while stalled")

  // Only fire beats leave the run open; every other kind closes it
  `ESD_ASSERT_NOW(a_last_kind, out_tvalid, out_tlast == (out_tuser != KIND_FIRE), "tlast does not match the result kind")

  // A full-table flag appears only on an assign reply with slot zero
  `ESD_ASSERT_NOW(a_full_reply, out_tvalid && out_tdata[14], (out_tuser == KIND_ASSIGN) && (out_tdata[4:0] == 5'd0), "table_full on a wrong beat")

  // The block works on one command at a time
  `ESD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accepting a command")

endmodule

bind event_slot_dispatcher esd_checker u_esd_checker (.*);

`default_nettype wire

[bench/tb_event_slot_dispatcher.sv]
`timescale 1ns / 1ps

module tb_event_slot_dispatcher;
  import esd_pkg::*;

  localparam int NSLOTS      = 32;
  localparam int HOLD_AT     = 150;  // accepted commands before the long receiver hold-off
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;   // margin after the last expected result

  // One command as the sender sees it. A drain entry is not sent: it makes
  // the sender wait until every predicted result has come back.
  typedef struct {
    cmd_t        cmd;
    logic [5:0]  src;
    logic        has_src;
    logic [7:0]  hnd;
    logic        has_hnd;
    logic [15:0] limit;
    logic [63:0] cond;
    bit          drain;
  } cmd_item_t;

  typedef struct {
    kind_t      kind;
    logic [4:0] slot;
    logic [7:0] hnd;
    logic       call;
    logic       full;
    logic       last;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;   // [5:0] source, [6] has_source, [14:7] handler,
                                  // [15] has_handler, [31:16] fire_limit, [95:32] conditions
  cmd_t        in_tuser   = CMD_ASSIGN_REP;  // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [4:0] slot, [12:5] fired_handler, [13] call_handler,
                                  // [14] table_full, [15] zero
  kind_t       out_tuser;         // [1:0] kind
  logic        out_tlast;

  event_slot_dispatcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ------------------------------------------------------------------
  // Shadow copy of the slot table, advanced once per accepted command
  // ------------------------------------------------------------------
  logic        sl_active  [NSLOTS];
  logic        sl_one_shot[NSLOTS];
  logic [15:0] sl_limit   [NSLOTS];
  logic [15:0] sl_count   [NSLOTS];
  logic [5:0]  sl_src     [NSLOTS];
  logic        sl_has_src [NSLOTS];
  logic [7:0]  sl_hnd     [NSLOTS];
  logic        sl_has_hnd [NSLOTS];

  cmd_item_t cmd_queue[$];    // commands waiting to be offered
  result_t   due_results[$];  // predicted result beats, oldest first

  int fail_count = 0;
  int in_count   = 0;
  int out_count  = 0;
  int n_queued   = 0;
  int n_ticks    = 0;
  int n_assigns  = 0;
  int n_refused  = 0;
  int n_clears   = 0;
  int n_fires    = 0;

  cmd_item_t drv_item;
  bit        in_fire    = 1'b0;  // command beat taken at the last rising edge
  bit        hold_drain = 1'b0;
  bit        hold_done  = 1'b0;
  int        hold_left  = 0;
  bit        calm;

  // no random idling on either side through this stretch of commands
  assign calm = (in_count >= 60) && (in_count < 110);

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      sl_active[i]   = 1'b0;
      sl_one_shot[i] = 1'b0;
      sl_limit[i]    = '0;
      sl_count[i]    = '0;
      sl_src[i]      = '0;
      sl_has_src[i]  = 1'b0;
      sl_hnd[i]      = '0;
      sl_has_hnd[i]  = 1'b0;
    end
  end

  function automatic result_t mk_result(input kind_t kind, input int slot, input logic [7:0] hnd,
                                        input logic call, input logic full, input logic last);
    result_t r;
    r.kind = kind;
    r.slot = slot[4:0];
    r.hnd  = hnd;
    r.call = call;
    r.full = full;
    r.last = last;
    return r;
  endfunction

  // Apply one command to the shadow table and queue the beats it must produce.
  function automatic void step_slot_table(input cmd_item_t it);
    bit placed;
    placed = 1'b0;
    case (it.cmd)
      CMD_ASSIGN_REP, CMD_ASSIGN_ONCE: begin
        n_assigns++;
        // take the lowest inactive slot
        for (int i = 0; i < NSLOTS; i++) begin
          if (!placed && !sl_active[i]) begin
            placed         = 1'b1;
            sl_active[i]   = 1'b1;
            sl_one_shot[i] = (it.cmd == CMD_ASSIGN_ONCE);
            sl_limit[i]    = (it.cmd == CMD_ASSIGN_ONCE) ? it.limit : 16'd0;
            sl_count[i]    = '0;
            sl_src[i]      = it.src;
            sl_has_src[i]  = it.has_src;
            sl_hnd[i]      = it.hnd;
            sl_has_hnd[i]  = it.has_hnd;
            due_results.push_back(mk_result(KIND_ASSIGN, i, 8'd0, 1'b0, 1'b0, 1'b1));
          end
        end
        if (!placed) begin
          n_refused++;
          due_results.push_back(mk_result(KIND_ASSIGN, 0, 8'd0, 1'b0, 1'b1, 1'b1));
        end
      end
      CMD_CLEAR: begin
        n_clears++;
        // clear counts of one-shot slots, active or not; reactivate nothing
        for (int i = 0; i < NSLOTS; i++)
          if (sl_one_shot[i]) sl_count[i] = '0;
        due_results.push_back(mk_result(KIND_ACK, 0, 8'd0, 1'b0, 1'b0, 1'b1));
      end
      default: begin
        n_ticks++;
        for (int i = 0; i < NSLOTS; i++) begin
          if (sl_active[i] && sl_has_src[i] && it.cond[sl_src[i]] &&
              !(sl_one_shot[i] && sl_count[i] >= sl_limit[i])) begin
            n_fires++;
            due_results.push_back(mk_result(KIND_FIRE, i, sl_has_hnd[i] ? sl_hnd[i] : 8'd0,
                                            sl_has_hnd[i], 1'b0, 1'b0));
            // repeating slots saturate, one-shots retire at their limit
            if (sl_count[i] != 16'hFFFF) sl_count[i] = sl_count[i] + 16'd1;
            if (sl_one_shot[i] && sl_count[i] >= sl_limit[i]) sl_active[i] = 1'b0;
          end
        end
        due_results.push_back(mk_result(KIND_DONE, 0, 8'd0, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Failure reporting: print one line per mismatch, count all
  // ------------------------------------------------------------------
  task automatic report_failure(input string msg);
    fail_count++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_failure($sformatf("beat %0d %s: got 0x%0h, want 0x%0h", out_count, name, got, want));
  endtask

  // ------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      in_count++;
      step_slot_table(drv_item);
    end
    if (rst_n && out_tvalid && out_tready) begin
      out_count++;
      if (due_results.size() == 0) begin
        report_failure($sformatf("beat %0d: result kind %0d with nothing expected",
                                 out_count, out_tuser));
      end else begin
        want = due_results.pop_front();
        compare_field("kind",          16'(out_tuser),     16'(want.kind));
        compare_field("slot",          16'(out_tdata[4:0]), 16'(want.slot));
        compare_field("fired_handler", 16'(out_tdata[12:5]), 16'(want.hnd));
        compare_field("call_handler",  16'(out_tdata[13]),  16'(want.call));
        compare_field("table_full",    16'(out_tdata[14]),  16'(want.full));
        compare_field("pad bit",       16'(out_tdata[15]),  16'd0);
        compare_field("last",          16'(out_tlast),      16'(want.last));
      end
    end
  end

  // ------------------------------------------------------------------
  // Driver: change inputs at the falling edge, hold a beat until taken
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold the offered beat
    end else begin
      if (hold_drain && due_results.size() == 0) hold_drain = 1'b0;
      if (!hold_drain && cmd_queue.size() > 0 && cmd_queue[0].drain) begin
        void'(cmd_queue.pop_front());
        hold_drain = 1'b1;
      end
      if (!hold_drain && cmd_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
        drv_item = cmd_queue.pop_front();
        in_tdata  <= {drv_item.cond, drv_item.limit, drv_item.has_hnd, drv_item.hnd,
                      drv_item.has_src, drv_item.src};
        in_tuser  <= drv_item.cmd;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off, which lets the
  // block back up and stall its command input while the sender keeps offering.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && in_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // ------------------------------------------------------------------
  // Command builders
  // ------------------------------------------------------------------
  function automatic cmd_item_t rand_item(input cmd_t c);
    cmd_item_t it;
    logic [31:0] r0, r1, r2;
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    it.cmd     = c;
    it.src     = r0[5:0];
    it.has_src = r0[6];
    it.hnd     = r0[14:7];
    it.has_hnd = r0[15];
    it.limit   = r0[31:16];
    it.cond    = {r1, r2};
    it.drain   = 1'b0;
    return it;
  endfunction

  // Well-formed assigns mostly watch a line and retire after a few firings,
  // so slots keep recycling; long-lived slots are kept rare.
  function automatic cmd_item_t mk_assign(input bit once, input bit short_life);
    cmd_item_t it;
    int r;
    logic [31:0] r0;
    it = rand_item(once ? CMD_ASSIGN_ONCE : CMD_ASSIGN_REP);
    r0 = $urandom;
    if (short_life) begin
      it.has_src = 1'b1;
      it.limit   = 16'($urandom_range(1, 3));
    end else begin
      it.has_src = ($urandom_range(0, 99) >= 4);
      r = $urandom_range(0, 99);
      if (r < 3)      it.limit = 16'd0;
      else if (r < 7) it.limit = r0[15:0];
      else            it.limit = 16'($urandom_range(1, 4));
    end
    return it;
  endfunction

  function automatic cmd_item_t mk_tick(input logic [63:0] cond);
    cmd_item_t it;
    it = rand_item(CMD_TICK);
    it.cond = cond;
    return it;
  endfunction

  function automatic cmd_item_t mk_slot(input cmd_t c, input logic [5:0] src, input logic has_src,
                                        input logic [7:0] hnd, input logic has_hnd,
                                        input logic [15:0] limit);
    cmd_item_t it;
    it = rand_item(c);
    it.src     = src;
    it.has_src = has_src;
    it.hnd     = hnd;
    it.has_hnd = has_hnd;
    it.limit   = limit;
    return it;
  endfunction

  function automatic logic [63:0] rand_cond();
    logic [31:0] a, b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
      default: return {a, b};
    endcase
  endfunction

  task automatic push_cmd(input cmd_item_t it);
    cmd_queue.push_back(it);
    n_queued++;
  endtask

  task automatic push_drain();
    cmd_item_t it;
    it = rand_item(CMD_TICK);
    it.drain = 1'b1;
    cmd_queue.push_back(it);
  endtask

  // ------------------------------------------------------------------
  // Stimulus and end of run
  // ------------------------------------------------------------------
  initial begin
    int round;
    round = 0;

    // directed: empty table, field extremes, slots that never fire
    push_cmd(mk_tick('1));                                         // nothing to fire yet
    push_cmd(rand_item(CMD_CLEAR));                                // clear on an empty table
    push_cmd(mk_slot(CMD_ASSIGN_REP,  6'd0,  1'b1, 8'hFF, 1'b1, 16'h1234));  // slot 0
    push_cmd(mk_slot(CMD_ASSIGN_REP,  6'd63, 1'b1, 8'h00, 1'b0, 16'hFFFF));  // slot 1, no call
    push_cmd(mk_slot(CMD_ASSIGN_REP,  6'd5,  1'b0, 8'h5A, 1'b1, 16'd0));     // slot 2, no line
    push_cmd(mk_slot(CMD_ASSIGN_ONCE, 6'd1,  1'b1, 8'h11, 1'b1, 16'd0));     // zero limit
    push_cmd(mk_slot(CMD_ASSIGN_ONCE, 6'd2,  1'b1, 8'hA5, 1'b1, 16'd2));     // slot 4
    push_cmd(mk_slot(CMD_ASSIGN_ONCE, 6'd3,  1'b1, 8'h3C, 1'b0, 16'hFFFF));  // handler dropped
    push_cmd(mk_tick('1));
    push_cmd(mk_tick('1));                                         // slot 4 retires here
    push_cmd(mk_tick('0));
    push_cmd(mk_tick(64'h8000_0000_0000_0001));                    // lowest and highest line
    push_cmd(mk_slot(CMD_ASSIGN_ONCE, 6'd2,  1'b1, 8'h81, 1'b1, 16'd1));     // reuses slot 4
    push_cmd(rand_item(CMD_CLEAR));
    push_cmd(mk_tick(64'h0000_0000_0000_000C));
    push_cmd(mk_tick('1));
    push_drain();

    // random rounds: a few assigns then ticks, with clears and noise mixed in
    while (n_queued < 260) begin
      round++;
      if (round == 6) begin
        // fill the table to overflow, then tick all lines until the new one-shot slots retire
        repeat (34) push_cmd(mk_assign(1'b1, 1'b1));
        repeat (3) push_cmd(mk_tick('1));
      end else if (round % 25 == 0) begin
        push_drain();
      end else begin
        repeat ($urandom_range(0, 4)) push_cmd(mk_assign($urandom_range(0, 99) >= 6, 1'b0));
        repeat ($urandom_range(1, 3)) push_cmd(mk_tick(rand_cond()));
        if ($urandom_range(0, 99) < 12) push_cmd(rand_item(CMD_CLEAR));
        if ($urandom_range(0, 99) < 8) push_cmd(rand_item(cmd_t'($urandom_range(0, 3))));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d ticks with %0d firings, %0d assigns (%0d refused)",
             in_count, n_ticks, n_fires, n_assigns, n_refused);
    $display("also %0d count clears; %0d result beats checked, %0d failures",
             n_clears, out_count, fail_count);
    if (fail_count == 0) begin
      $display("** event_slot_dispatcher: PASSED **");
    end else begin
      $display("** event_slot_dispatcher: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("timeout: %0d commands taken, %0d results still due", in_count, due_results.size());
    $display("** event_slot_dispatcher: FAILED **");
    $finish;
  end

endmodule
